// File: rtl/tga_rle_pixel_decoder_macros.svh
// Assertion macros for the TGA run-length pixel decoder.
// Every module that asserts uses the clock clk and the reset arst_n.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_RLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga_rle: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TGA_RLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga_rle: next-cycle check failed");

`else

`define TGA_RLE_ASSERT_IMP(lbl, ante, cons)
`define TGA_RLE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/tga_rle_pkg.sv
`default_nettype none

package tga_rle_pkg;

	// Packet header codes: below the limit a raw packet, else a run.
	localparam logic [7:0] RAW_LIMIT = 8'd128;
	localparam logic [7:0] RUN_BIAS  = 8'd127;

	// Pixel size selection; any other value decodes as three bytes.
	localparam logic [2:0] BPP_FOUR = 3'd4;

	// Configuration register indexes (paddr[2]).
	localparam logic REG_BPP   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One decoded pixel as handed from the front to the back.
	typedef struct packed {
		logic [31:0] color;   // stored bytes, first byte lowest
		logic        four;    // pixel had four bytes (alpha valid)
		logic [7:0]  count;   // repeat count
		logic        done;    // last pixel of the image
		logic        err;     // pixel overran the image total
	} pix_event_t;

endpackage

`default_nettype wire

// File: rtl/tga_rle_pixel_decoder.sv
// Channel   | Dir | Signals                              | Contents
// ----------+-----+--------------------------------------+-------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata[7:0]       | data_byte
// m_*       | out | m_tvalid m_tready m_tdata[39:0]      | red green blue alpha repeat_count
//           |     | m_tlast, m_tuser                     | image_done, overrun_error
// APB       | in  | psel penable pwrite paddr[2:0] ...   | 0: bytes_per_pixel 4: pixel_total
//
// One input byte is taken every cycle while the two-entry event queue has room;
// the front's header, byte assembly and 33-bit total compare finish in that cycle.
// A completed pixel is registered in the event queue and then in the output register.
// A stalled sink fills the output register and then the queue, after which
// s_tready falls; reset returns to expecting a packet header with a zero count.
`default_nettype none

module tga_rle_pixel_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,    // [7:0] red, [15:8] green, [23:16] blue,
	                                     // [31:24] alpha, [39:32] repeat_count
	output logic             m_tlast,    // image_done
	output logic             m_tuser,    // [0] overrun_error
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [2:0]  bpp_q;
	logic [31:0] total_q;
	logic        cfg_wr;
	logic        accept;
	logic        push;
	logic        full;
	logic        pop;
	logic        empty;

	tga_rle_pkg::pix_event_t front_event;
	tga_rle_pkg::pix_event_t head_event;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= 3'd4;
			total_q <= 32'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tga_rle_pkg::REG_BPP:   bpp_q   <= pwdata[2:0];
				tga_rle_pkg::REG_TOTAL: total_q <= pwdata;
				default:                bpp_q   <= bpp_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tga_rle_pkg::REG_BPP:   prdata = {29'd0, bpp_q};
			tga_rle_pkg::REG_TOTAL: prdata = total_q;
			default:                prdata = 32'd0;
		endcase
	end

	// Input beats are taken while the queue has room.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	tga_rle_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (s_tdata),
		.bytes_per_pixel (bpp_q),
		.pixel_total     (total_q),
		.push            (push),
		.event_out       (front_event)
	);

	tga_rle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_event),
		.full      (full),
		.pop       (pop),
		.pop_data  (head_event),
		.empty     (empty)
	);

	tga_rle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (head_event),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: rtl/tga_rle_front.sv
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

// Front end: parses packet headers, assembles pixel bytes and keeps the
// pixel count of the image, producing one event per completed pixel.
module tga_rle_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [7:0]             data_byte,
	input  wire logic [2:0]             bytes_per_pixel,
	input  wire logic [31:0]            pixel_total,
	output logic                        push,
	output tga_rle_pkg::pix_event_t     event_out
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_RAW    = 2'd1;
	localparam logic [1:0] PH_RUN    = 2'd2;

	logic [1:0]  phase_q;
	logic [7:0]  left_q;
	logic [1:0]  bip_q;
	logic [31:0] asm_q;
	logic [31:0] done_cnt_q;

	logic        four;
	logic        in_packet;
	logic [1:0]  bip_nx;
	logic        complete;
	logic [4:0]  lane_shift;
	logic [31:0] color;
	logic [7:0]  count;
	logic [32:0] reached;
	logic        over;
	logic [7:0]  left_nx;
	logic        end_img;
	logic [7:0]  hdr_left;
	logic [1:0]  hdr_phase;

	// Pixel size, byte position and the merged colour word.
	always_comb begin
		four       = (bytes_per_pixel == tga_rle_pkg::BPP_FOUR);
		bip_nx     = bip_q + 2'd1;
		complete   = (bip_nx == 2'd0) || (!four && (bip_nx == 2'd3));
		lane_shift = {bip_q, 3'b000};
		color      = asm_q | ({24'd0, data_byte} << lane_shift);
	end

	// Pixel accounting against the image total.
	always_comb begin
		count   = (phase_q == PH_RAW) ? 8'd1 : left_q;
		reached = {1'b0, done_cnt_q} + {25'd0, count};
		over    = reached > {1'b0, pixel_total};
		left_nx = left_q - count;
		end_img = (left_nx == 8'd0) && (reached[31:0] == pixel_total);
	end

	// Packet header classification.
	always_comb begin
		if (data_byte < tga_rle_pkg::RAW_LIMIT) begin
			hdr_phase = PH_RAW;
			hdr_left  = data_byte + 8'd1;
		end else begin
			hdr_phase = PH_RUN;
			hdr_left  = data_byte - tga_rle_pkg::RUN_BIAS;
		end
	end

	always_comb begin
		unique case (phase_q) inside
			PH_RAW, PH_RUN: in_packet = 1'b1;
			default:        in_packet = 1'b0;
		endcase
	end

	// A completed pixel becomes an event.
	assign push            = accept && in_packet && complete;
	assign event_out.color = color;
	assign event_out.four  = four;
	assign event_out.count = count;
	assign event_out.done  = !over && end_img;
	assign event_out.err   = over;

	// Decode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			left_q     <= 8'd0;
			bip_q      <= 2'd0;
			asm_q      <= 32'd0;
			done_cnt_q <= 32'd0;
		end else if (accept) begin
			if (!in_packet) begin
				phase_q <= hdr_phase;
				left_q  <= hdr_left;
				bip_q   <= 2'd0;
				asm_q   <= 32'd0;
			end else if (!complete) begin
				bip_q <= bip_nx;
				asm_q <= color;
			end else begin
				bip_q <= 2'd0;
				asm_q <= 32'd0;
				if (over || end_img) begin
					// The image ends, by overrun or by reaching its total.
					phase_q    <= PH_HEADER;
					left_q     <= 8'd0;
					done_cnt_q <= 32'd0;
				end else begin
					done_cnt_q <= reached[31:0];
					left_q     <= left_nx;
					if (left_nx == 8'd0) begin
						phase_q <= PH_HEADER;
					end
				end
			end
		end
	end

	`TGA_RLE_ASSERT_NXT(a_end_restarts, push && (event_out.done || event_out.err), (phase_q == PH_HEADER) && (done_cnt_q == 32'd0))
	`TGA_RLE_ASSERT_IMP(a_header_aligned, phase_q == PH_HEADER, (bip_q == 2'd0) && (asm_q == 32'd0))
	`TGA_RLE_ASSERT_IMP(a_flags_exclusive, push, !(event_out.done && event_out.err))

endmodule

`default_nettype wire

// File: rtl/tga_rle_queue.sv
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

// Short first-in first-out queue of pixel events between front and back.
module tga_rle_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire tga_rle_pkg::pix_event_t push_data,
	output logic                        full,
	input  wire logic                   pop,
	output tga_rle_pkg::pix_event_t     pop_data,
	output logic                        empty
);

	tga_rle_pkg::pix_event_t entry_q [tga_rle_pkg::QDEPTH];

	logic [tga_rle_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tga_rle_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tga_rle_pkg::QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == tga_rle_pkg::QCNT_W'(tga_rle_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`TGA_RLE_ASSERT_IMP(a_no_push_full, push, !full)
	`TGA_RLE_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule

`default_nettype wire

// File: rtl/tga_rle_back.sv
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

// Back end: takes events from the queue, reorders the colour bytes to RGB
// with alpha, and holds the result beat until the sink takes it.
module tga_rle_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   empty,
	input  wire tga_rle_pkg::pix_event_t pop_data,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [39:0]                 m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);

	logic        valid_q;
	logic [39:0] data_q;
	logic        last_q;
	logic        user_q;
	logic [7:0]  alpha;

	// The output register is free when empty or when its beat is taken.
	assign pop   = !empty && (!valid_q || m_tready);
	assign alpha = pop_data.four ? pop_data.color[31:24] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload: red, green, blue, alpha, repeat count.
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {pop_data.count, alpha, pop_data.color[7:0],
				pop_data.color[15:8], pop_data.color[23:16]};
			last_q <= pop_data.done;
			user_q <= pop_data.err;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

	`TGA_RLE_ASSERT_NXT(a_pop_loads, pop, valid_q)

endmodule

`default_nettype wire

// File: tb/tga_rle_pixel_decoder_tb.sv
`default_nettype none

module tga_rle_pixel_decoder_tb;

	// Decoder position within the coded stream.
	typedef enum logic [1:0] {
		DEC_HEADER,
		DEC_RAW,
		DEC_RUN
	} decode_phase_t;

	// One output pixel beat, field by field.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       image_done;
		logic       overrun_error;
	} pixel_beat_t;

	// Directed stimulus: a byte to send or a register to set.
	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_SET_BPP,
		ROW_SET_TOTAL
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;
		logic        typed;
		pixel_beat_t beat;
	} stim_row_t;

	localparam int PLAN_LEN = 26;
	localparam int TOTAL_BYTES = 940;

	// Bytes with a typed result give the pixel that the row completes.
	localparam stim_row_t PLAN [PLAN_LEN] = '{
		// Reset settings: four-byte pixels, one pixel per image.
		'{ROW_BYTE, 32'h80, 1'b0, '0},
		'{ROW_BYTE, 32'h11, 1'b0, '0},
		'{ROW_BYTE, 32'h22, 1'b0, '0},
		'{ROW_BYTE, 32'h33, 1'b0, '0},
		'{ROW_BYTE, 32'h44, 1'b1, '{8'h33, 8'h22, 8'h11, 8'h44, 8'd1, 1'b1, 1'b0}},
		// A zero total overruns on the first pixel.
		'{ROW_SET_TOTAL, 32'd0, 1'b0, '0},
		'{ROW_BYTE, 32'h7F, 1'b0, '0},
		'{ROW_BYTE, 32'hFF, 1'b0, '0},
		'{ROW_BYTE, 32'hFF, 1'b0, '0},
		'{ROW_BYTE, 32'hFF, 1'b0, '0},
		'{ROW_BYTE, 32'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0, 1'b1}},
		// An odd pixel size decodes as three bytes; the total is met inside
		// a raw packet, so the packet's next pixel overruns.
		'{ROW_SET_BPP, 32'd0, 1'b0, '0},
		'{ROW_SET_TOTAL, 32'd1, 1'b0, '0},
		'{ROW_BYTE, 32'h01, 1'b0, '0},
		'{ROW_BYTE, 32'hA0, 1'b0, '0},
		'{ROW_BYTE, 32'hB0, 1'b0, '0},
		'{ROW_BYTE, 32'hC0, 1'b1, '{8'hC0, 8'hB0, 8'hA0, 8'h00, 8'd1, 1'b0, 1'b0}},
		'{ROW_BYTE, 32'hD0, 1'b0, '0},
		'{ROW_BYTE, 32'hE0, 1'b0, '0},
		'{ROW_BYTE, 32'hF0, 1'b1, '{8'hF0, 8'hE0, 8'hD0, 8'h00, 8'd1, 1'b0, 1'b1}},
		// Longest run against an image total of hex FFFE0001.
		'{ROW_SET_BPP, 32'd3, 1'b0, '0},
		'{ROW_SET_TOTAL, 32'hFFFE0001, 1'b0, '0},
		'{ROW_BYTE, 32'hFF, 1'b0, '0},
		'{ROW_BYTE, 32'h01, 1'b0, '0},
		'{ROW_BYTE, 32'h02, 1'b0, '0},
		'{ROW_BYTE, 32'h03, 1'b1, '{8'h03, 8'h02, 8'h01, 8'h00, 8'd128, 1'b0, 1'b0}}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Register copies and decoder state as predicted.
	logic [2:0]    cfg_bpp = tga_rle_pkg::BPP_FOUR;
	logic [31:0]   cfg_total = 32'd1;
	decode_phase_t dec_phase = DEC_HEADER;
	logic [7:0]    pkt_left = 8'd0;
	logic [1:0]    byte_idx = 2'd0;
	logic [31:0]   color_acc = 32'd0;
	logic [31:0]   pix_count = 32'd0;

	pixel_beat_t expected_pixels [$];
	int          pixels_predicted = 0;
	int          bytes_sent = 0;
	int          errors = 0;
	int          stall_left = 0;
	bit          steady = 1'b0;
	pixel_beat_t want_beat;
	pixel_beat_t got_beat;

	tga_rle_pixel_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A safety net in case the design hangs.
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int stall_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void start_image();
		dec_phase = DEC_HEADER;
		pkt_left  = 8'd0;
		byte_idx  = 2'd0;
		color_acc = 32'd0;
		pix_count = 32'd0;
	endfunction

	function automatic void push_pixel(input logic [31:0] color, input logic four,
			input logic [7:0] count, input logic done, input logic err);
		pixel_beat_t beat;
		beat.red           = color[23:16];
		beat.green         = color[15:8];
		beat.blue          = color[7:0];
		beat.alpha         = four ? color[31:24] : 8'd0;
		beat.repeat_count  = count;
		beat.image_done    = done;
		beat.overrun_error = err;
		expected_pixels.push_back(beat);
		pixels_predicted++;
	endfunction

	// Advance the predicted decoder by one accepted byte.
	function automatic void decode_byte(input logic [7:0] b);
		logic        four;
		logic [2:0]  need;
		logic [31:0] color;
		logic [7:0]  count;
		logic [32:0] reached;
		four = (cfg_bpp == tga_rle_pkg::BPP_FOUR);
		need = four ? 3'd4 : 3'd3;
		// A packet header picks raw or run and the pixel count.
		if (dec_phase == DEC_HEADER) begin
			if (b < tga_rle_pkg::RAW_LIMIT) begin
				dec_phase = DEC_RAW;
				pkt_left  = b + 8'd1;
			end else begin
				dec_phase = DEC_RUN;
				pkt_left  = b - tga_rle_pkg::RUN_BIAS;
			end
			byte_idx  = 2'd0;
			color_acc = 32'd0;
			return;
		end
		color_acc = color_acc | (32'(b) << (8 * byte_idx));
		byte_idx  = byte_idx + 2'd1;
		if (byte_idx != 2'd0 && {1'b0, byte_idx} < need)
			return;
		color     = color_acc;
		byte_idx  = 2'd0;
		color_acc = 32'd0;
		count     = (dec_phase == DEC_RAW) ? 8'd1 : pkt_left;
		reached   = {1'b0, pix_count} + 33'(count);
		// Too many pixels: report the overrun and start afresh.
		if (reached > {1'b0, cfg_total}) begin
			push_pixel(color, four, count, 1'b0, 1'b1);
			start_image();
			return;
		end
		pix_count = reached[31:0];
		pkt_left  = pkt_left - count;
		if (pkt_left == 8'd0) begin
			if (pix_count == cfg_total) begin
				push_pixel(color, four, count, 1'b1, 1'b0);
				start_image();
				return;
			end
			dec_phase = DEC_HEADER;
		end
		push_pixel(color, four, count, 1'b0, 1'b0);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Sink side: accept beats, stalling at random outside steady stretches.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			stall_left <= stall_length();
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare every accepted pixel beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
				m_tdata[39:32], m_tlast, m_tuser};
			if (expected_pixels.size() == 0) begin
				$display("%0t: no pixel expected, got %h", $time, got_beat);
				errors++;
			end else begin
				want_beat = expected_pixels.pop_front();
				check_field("red", want_beat.red, got_beat.red);
				check_field("green", want_beat.green, got_beat.green);
				check_field("blue", want_beat.blue, got_beat.blue);
				check_field("alpha", want_beat.alpha, got_beat.alpha);
				check_field("repeat_count", want_beat.repeat_count, got_beat.repeat_count);
				check_field("image_done", 8'(want_beat.image_done), 8'(got_beat.image_done));
				check_field("overrun_error", 8'(want_beat.overrun_error),
					8'(got_beat.overrun_error));
			end
		end
	end

	// Offer one byte and wait until its beat is taken.
	task automatic offer_byte(input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	// Maybe leave a gap before the next byte.
	task automatic idle_gap();
		int gap;
		gap = (steady || $urandom_range(0, 9) < 7) ? 0 : stall_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Offer one byte, wait for its beat, then maybe leave a gap.
	task automatic send_byte(input logic [7:0] b);
		offer_byte(b);
		idle_gap();
	endtask

	// Stop sending and wait for every predicted pixel, plus the pipeline depth.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write a register once every predicted pixel has left, then read it back.
	task automatic set_register(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		drain_results();
		want    = (idx == tga_rle_pkg::REG_BPP) ? {29'd0, value[2:0]} : value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == tga_rle_pkg::REG_BPP)
			cfg_bpp = value[2:0];
		else
			cfg_total = value;
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d expected %0h, got %0h", $time, idx, want, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly well-formed packets sized to the remaining image, with some noise,
	// truncated packets and oversized ones mixed in.
	task automatic send_image();
		int     packets;
		int     need;
		int     cap;
		int     n;
		int     r;
		int     nbytes;
		bit     is_run;
		longint rem;
		packets = 0;
		do begin
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			need   = (cfg_bpp == tga_rle_pkg::BPP_FOUR) ? 4 : 3;
			rem    = longint'(cfg_total) - longint'(pix_count);
			if (rem < 1)
				rem = 1;
			cap    = (rem > 128) ? 128 : int'(rem);
			is_run = $urandom_range(0, 1);
			r      = $urandom_range(0, 39);
			if (r == 0)
				n = $urandom_range(1, 128);
			else if (is_run)
				n = (r < 12) ? cap : $urandom_range(1, cap);
			else
				n = $urandom_range(1, (cap > 5) ? 5 : cap);
			send_byte(is_run ? 8'(n + 127) : 8'(n - 1));
			nbytes = is_run ? need : n * need;
			if (r == 1)
				nbytes = $urandom_range(0, nbytes - 1);
			repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
			packets++;
		end while (!(dec_phase == DEC_HEADER && pix_count == 32'd0) && packets < 8
			&& bytes_sent < TOTAL_BYTES);
	endtask

	// Random register settings, extremes among them.
	task automatic pick_settings();
		int          r;
		logic [2:0]  bpp;
		logic [31:0] total;
		r   = $urandom_range(0, 9);
		bpp = (r < 4) ? 3'd3 : (r < 8) ? tga_rle_pkg::BPP_FOUR : 3'($urandom_range(0, 7));
		r   = $urandom_range(0, 10);
		case (r)
			6: total = 32'd0;
			7: total = 32'd1;
			8: total = 32'hFFFE0001;
			9: total = 32'hFFFFFFFF;
			10: total = $urandom;
			default: total = $urandom_range(1, 12);
		endcase
		case ($urandom_range(0, 3))
			0: set_register(tga_rle_pkg::REG_BPP, {29'd0, bpp});
			1: set_register(tga_rle_pkg::REG_TOTAL, total);
			2: begin
				set_register(tga_rle_pkg::REG_BPP, {29'd0, bpp});
				set_register(tga_rle_pkg::REG_TOTAL, total);
			end
			default: drain_results();
		endcase
	endtask

	// Reset, directed table, random phases, then wind down.
	initial begin
		int prev_predicted;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			case (PLAN[i].kind)
				ROW_SET_BPP: set_register(tga_rle_pkg::REG_BPP, PLAN[i].value);
				ROW_SET_TOTAL: set_register(tga_rle_pkg::REG_TOTAL, PLAN[i].value);
				default: begin
					prev_predicted = pixels_predicted;
					offer_byte(PLAN[i].value[7:0]);
					// The typed pixel replaces the prediction before its beat can leave.
					if (PLAN[i].typed) begin
						if (pixels_predicted == prev_predicted) begin
							$display("%0t: row %0d expected %h, predicted none", $time, i,
								PLAN[i].beat);
							errors++;
						end else begin
							expected_pixels[expected_pixels.size() - 1] = PLAN[i].beat;
						end
					end
					idle_gap();
				end
			endcase
		end

		while (bytes_sent < TOTAL_BYTES) begin
			pick_settings();
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 4)) begin
				if (bytes_sent < TOTAL_BYTES)
					send_image();
			end
		end

		steady = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/tga_rle_pkg.sv
rtl/tga_rle_front.sv
rtl/tga_rle_queue.sv
rtl/tga_rle_back.sv
rtl/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_tb.sv
